[sv/fefl_pkg.sv]
// Package for the fixed-entry free list allocator.
// Holds entry number width, controller/datapath command and status types.
// No dependencies.
`timescale 1ns / 1ps

package fefl_pkg;

  // Entry numbers are 12 bits wide; zero is the null entry
  localparam int unsigned ENTRY_W     = 12;
  localparam int unsigned ENTRY_SPACE = 4096;

  // Source of the result that the output register takes
  typedef enum logic [1:0] {
    RSP_NONE = 2'd0,
    RSP_POP  = 2'd1,
    RSP_FILL = 2'd2
  } rsp_kind_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic      capture;   // take the item and start the index fold
    logic      free_wr;   // write old head into the freed entry's link
    logic      pop_rd;    // read the head's link
    logic      pop_upd;   // move the head to the link just read
    logic      fill_wr;   // chain one entry of the fresh block
    logic      out_load;  // load the output register
    rsp_kind_e out_kind;  // what the output register takes
  } fefl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_free;        // offered item is a free request
    logic in_addr_zero;   // offered entry to free is null
    logic in_fresh_zero;  // offered fresh block is null
    logic head_zero;      // free list is empty
    logic fill_last;      // current chaining step is the block's last entry
  } fefl_status_t;

endpackage

[sv/fefl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Holds the next links of the free list. No dependencies.
`timescale 1ns / 1ps

module fefl_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/fefl_datapath.sv]
// Datapath of the free list allocator: head register, captured item, link index
// fold, block chaining walk, link memory and output register.
// Depends on fefl_pkg and fefl_ram.
`timescale 1ns / 1ps

module fefl_datapath import fefl_pkg::*; #(
  parameter int unsigned POOL_ENTRIES  = 4096,
  parameter int unsigned BLOCK_ENTRIES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fefl_cmd_t          cmd_i,
  output fefl_status_t       status_o,
  input  logic               req_type_i,
  input  logic [ENTRY_W-1:0] entry_addr_i,
  input  logic [ENTRY_W-1:0] fresh_block_i,
  output logic [ENTRY_W-1:0] granted_entry_o,
  output logic               block_taken_o
);

  // Link memory covers every index an entry number can fold to
  localparam int unsigned DEPTH = (POOL_ENTRIES < ENTRY_SPACE) ? POOL_ENTRIES : ENTRY_SPACE;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(BLOCK_ENTRIES);

  logic [ENTRY_W-1:0] head_d, head_q;
  logic [ENTRY_W-1:0] addr_q;
  logic [ENTRY_W-1:0] fresh_q;
  logic [ENTRY_W-1:0] operand_d, operand_q;
  logic [IDX_W-1:0]   calc_idx;
  logic [CNT_W-1:0]   cnt_d, cnt_q;
  logic [IDX_W-1:0]   run_idx_d, run_idx_q;
  logic [IDX_W-1:0]   fill_idx;
  logic [ENTRY_W-1:0] fill_cur, fill_nxt, fill_link;
  logic               fill_last;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [ENTRY_W-1:0] grant_d, grant_q;
  logic               taken_q;

  // Status of the offered item and the list
  assign status_o.in_free       = req_type_i;
  assign status_o.in_addr_zero  = (entry_addr_i == '0);
  assign status_o.in_fresh_zero = (fresh_block_i == '0);
  assign status_o.head_zero     = (head_q == '0);
  assign status_o.fill_last     = fill_last;

  // Pick the entry whose link index is needed: freed entry, head, or fresh block
  always_comb begin
    if (req_type_i) begin
      operand_d = entry_addr_i;
    end else if (head_q != '0) begin
      operand_d = head_q;
    end else begin
      operand_d = fresh_block_i;
    end
  end

  // Capture the item
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      addr_q    <= entry_addr_i;
      fresh_q   <= fresh_block_i;
      operand_q <= operand_d;
    end
  end

  // Fold the entry number into a link index (entry modulo POOL_ENTRIES)
  if (POOL_ENTRIES < ENTRY_SPACE) begin : g_fold
    // Quotient by reciprocal; exact for 12-bit entries with a 24-bit scale
    localparam int unsigned RECIP = ((1 << 24) + POOL_ENTRIES - 1) / POOL_ENTRIES;
    logic [32:0]        prod;
    logic [ENTRY_W-1:0] quot_d, quot_q;
    logic [23:0]        back;

    assign prod   = 33'(operand_d) * 33'(RECIP);
    assign quot_d = ENTRY_W'(prod >> 24);

    always_ff @(posedge clk_i) begin
      if (cmd_i.capture) begin
        quot_q <= quot_d;
      end
    end

    // Remainder from the registered quotient
    assign back     = 24'(quot_q) * 24'(POOL_ENTRIES);
    assign calc_idx = IDX_W'(operand_q - back[ENTRY_W-1:0]);
  end else begin : g_direct
    assign calc_idx = operand_q[IDX_W-1:0];
  end

  // Chain walk over the fresh block: entry, its link and its index
  assign fill_cur  = fresh_q + ENTRY_W'(cnt_q);
  assign fill_nxt  = fill_cur + 1'b1;
  assign fill_last = (cnt_q == CNT_W'(BLOCK_ENTRIES - 1));
  assign fill_link = fill_last ? '0 : fill_nxt;
  assign fill_idx  = (cnt_q == '0) ? calc_idx : run_idx_q;

  // Advance the index alongside the entry; wrap at the pool and at entry zero
  always_comb begin
    if (fill_nxt == '0) begin
      run_idx_d = '0;
    end else if (fill_idx == IDX_W'(DEPTH - 1)) begin
      run_idx_d = '0;
    end else begin
      run_idx_d = fill_idx + 1'b1;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.capture) begin
      cnt_d = '0;
    end else if (cmd_i.fill_wr) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_wr) begin
      run_idx_q <= run_idx_d;
    end
  end

  // Link memory access
  assign ram_we    = cmd_i.free_wr | cmd_i.fill_wr;
  assign ram_waddr = cmd_i.fill_wr ? fill_idx : calc_idx;
  assign ram_wdata = cmd_i.fill_wr ? fill_link : head_q;

  fefl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.pop_rd),
    .raddr_i (calc_idx),
    .rdata_o (ram_rdata)
  );

  // Head update: push freed entry, pop to link, or restart after refill
  always_comb begin
    head_d = head_q;
    if (cmd_i.free_wr) begin
      head_d = addr_q;
    end else if (cmd_i.pop_upd) begin
      head_d = ram_rdata;
    end else if (cmd_i.fill_wr && fill_last) begin
      head_d = fresh_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else begin
      head_q <= head_d;
    end
  end

  // Output register
  always_comb begin
    case (cmd_i.out_kind)
      RSP_POP:  grant_d = operand_q;
      RSP_FILL: grant_d = fresh_q;
      default:  grant_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      grant_q <= grant_d;
      taken_q <= (cmd_i.out_kind == RSP_FILL);
    end
  end

  assign granted_entry_o = grant_q;
  assign block_taken_o   = taken_q;

endmodule

[sv/fefl_ctrl.sv]
// Controller of the free list allocator: one-hot state machine that sequences
// the datapath and owns the handshakes. Depends on fefl_pkg.
`timescale 1ns / 1ps

module fefl_ctrl import fefl_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  fefl_status_t status_i,
  output fefl_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_FREE   = 6'b000010,
    ST_LOOKUP = 6'b000100,
    ST_POP    = 6'b001000,
    ST_FILL   = 6'b010000,
    ST_RESP   = 6'b100000
  } state_e;

  state_e    state_d, state_q;
  rsp_kind_e kind_d, kind_q;
  logic      out_valid_d, out_valid_q;
  logic      slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    cmd_o    = '0;
    cmd_o.out_kind = kind_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          kind_d = RSP_NONE;
          if (status_i.in_free) begin
            state_d = status_i.in_addr_zero ? ST_RESP : ST_FREE;
          end else if (!status_i.head_zero) begin
            state_d = ST_LOOKUP;
            kind_d  = RSP_POP;
          end else if (!status_i.in_fresh_zero) begin
            state_d = ST_FILL;
            kind_d  = RSP_FILL;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_FREE: begin
        cmd_o.free_wr = 1'b1;
        state_d = ST_RESP;
      end
      ST_LOOKUP: begin
        cmd_o.pop_rd = 1'b1;
        state_d = ST_POP;
      end
      ST_POP: begin
        cmd_o.pop_upd = 1'b1;
        state_d = ST_RESP;
      end
      ST_FILL: begin
        cmd_o.fill_wr = 1'b1;
        if (status_i.fill_last) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        // Hand the result over once the output register is free
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= RSP_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[sv/fixed_entry_free_list_allocator.sv]
// Fixed-entry allocator over a singly linked free list. One item is a request:
// allocate (pop the head, or with an empty list chain a fresh block of
// BLOCK_ENTRIES entries and hand out its first) or free (push the entry as the
// new head); each item gives exactly one result. Entry 0 is null. The block
// works on one item at a time, taking the next the cycle after the result is
// loaded. An ignored item (free of null, or empty list with null block) only
// gives its result; a free links the freed entry to the old head, an allocate
// reads the head's link and moves the head, and a refill chains each entry of
// the block. The steps come from the link memory: one write port walked once
// per chained entry, a registered read per pop, and a registered fold of the
// entry number into a link index. The link memory is not cleared after reset.
`timescale 1ns / 1ps

module fixed_entry_free_list_allocator import fefl_pkg::*; #(
  parameter int unsigned POOL_ENTRIES  = 4096,
  parameter int unsigned BLOCK_ENTRIES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [ENTRY_W-1:0] entry_addr_i,
  input  logic [ENTRY_W-1:0] fresh_block_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ENTRY_W-1:0] granted_entry_o,
  output logic               block_taken_o
);

  fefl_cmd_t    cmd;
  fefl_status_t status;

  // Sequencer
  fefl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Head, link memory and result
  fefl_datapath #(
    .POOL_ENTRIES  (POOL_ENTRIES),
    .BLOCK_ENTRIES (BLOCK_ENTRIES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .req_type_i      (req_type_i),
    .entry_addr_i    (entry_addr_i),
    .fresh_block_i   (fresh_block_i),
    .granted_entry_o (granted_entry_o),
    .block_taken_o   (block_taken_o)
  );

`ifndef ASSERT_OFF
  // An accepted item keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted again right after an item");

  // Link read data is consumed in the cycle it arrives
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop_rd |=> cmd.pop_upd)
    else $error("pop did not follow the link read");

  // Chaining does not stop before the block's last entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.fill_wr && !status.fill_last) |=> cmd.fill_wr)
    else $error("block chaining stopped early");

  // A refill always hands out a non-null entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && block_taken_o) |-> (granted_entry_o != '0))
    else $error("refill result with null entry");
`endif

endmodule
